/* rtl/abr_pkg.sv */
// ----------------------------------------------------------------------------
// abr_pkg
// Shared widths, register map and field layout for the ARGB over RGB565 blend.
// ----------------------------------------------------------------------------
package abr_pkg;

  // one color channel at full precision
  localparam int unsigned ChanW = 8;

  // streaming payload widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    RegBlendEnable = 1'b0
  } reg_idx_e;

  // rgb565 field positions
  localparam int unsigned RedHi   = 15;
  localparam int unsigned RedLo   = 11;
  localparam int unsigned GreenHi = 10;
  localparam int unsigned GreenLo = 5;
  localparam int unsigned BlueHi  = 4;
  localparam int unsigned BlueLo  = 0;

  // one source pixel plus the destination pixel under it
  typedef struct packed {
    logic [15:0]      dest_pixel;
    logic [ChanW-1:0] src_blue;
    logic [ChanW-1:0] src_green;
    logic [ChanW-1:0] src_red;
    logic [ChanW-1:0] src_alpha;
  } in_item_t;

  // truncate three 8-bit channels to rgb565
  function automatic logic [OutDataW-1:0] pack565(input logic [ChanW-1:0] r,
                                                   input logic [ChanW-1:0] g,
                                                   input logic [ChanW-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/abr_mix.sv */
// ----------------------------------------------------------------------------
// abr_mix
// One channel blend: (s*a + d*(255-a)) / 255 with the exact shift-add divide.
// ----------------------------------------------------------------------------
module abr_mix (
  input  logic [abr_pkg::ChanW-1:0] src_i,
  input  logic [abr_pkg::ChanW-1:0] dst_i,
  input  logic [abr_pkg::ChanW-1:0] alpha_i,
  output logic [abr_pkg::ChanW-1:0] mix_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic [17:0]        base;
  logic [17:0]        sum;
  logic [15:0]        p;
  logic [8:0]         rnd;

  // s*a + d*(255-a) = d*255 + (s-d)*a, one multiplier
  assign diff = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
  assign prod = diff * $signed({1'b0, alpha_i});
  assign base = {2'b00, dst_i, 8'h00} - {10'd0, dst_i};
  assign sum  = base + $unsigned(prod);
  assign p    = sum[15:0];

  // divide by 255: hi + carry of (hi + lo + 1)
  assign rnd   = {1'b0, p[15:8]} + {1'b0, p[7:0]} + 9'd1;
  assign mix_o = p[15:8] + {7'd0, rnd[8]};

endmodule

/* rtl/abr_cfg.sv */
// ----------------------------------------------------------------------------
// abr_cfg
// APB register file holding the blend enable bit.
// ----------------------------------------------------------------------------
module abr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [abr_pkg::ApbAddrW-1:0] paddr,
  input  logic [abr_pkg::ApbDataW-1:0] pwdata,
  output logic [abr_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output logic                         blend_enable_o
);

  abr_pkg::reg_idx_e reg_idx;
  logic              wr_en;
  logic              blend_enable_q;
  logic              blend_enable_d;

  assign pready  = 1'b1;
  assign reg_idx = abr_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    blend_enable_d = blend_enable_q;
    prdata         = '0;
    case (reg_idx)
      abr_pkg::RegBlendEnable: begin
        prdata = {{(abr_pkg::ApbDataW-1){1'b0}}, blend_enable_q};
        if (wr_en) begin
          blend_enable_d = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_enable_q <= 1'b0;
    end else begin
      blend_enable_q <= blend_enable_d;
    end
  end

  assign blend_enable_o = blend_enable_q;

endmodule

/* rtl/argb_over_rgb565_blend.sv */
// ----------------------------------------------------------------------------
// argb_over_rgb565_blend
// Blends an ARGB8888 source pixel over an RGB565 destination pixel.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one source pixel and the framebuffer pixel under it per
//   transaction; m_axis returns the new rgb565 pixel, one per input
//   transaction, in order
//   the apb port holds blend_enable at address 0; with it clear the source
//   color is truncated to 565, with it set each channel is blended by alpha
//   (destination widened by bit replication, exact divide by 255)
//   an input transaction reaches the output transaction through the input
//   register, the blend logic and the result register
//   throughput is one pixel per cycle while m_axis_tready stays high, set by
//   the combinational blend path (one 9x9 multiplier per channel) between
//   the two registers
//   when m_axis_tready is low the result register holds, the input register
//   still fills, and s_axis_tready drops only once both are occupied
//   reset clears both valid flags and blend_enable; no data is buffered
//   write blend_enable only while no pixel is in flight
// ----------------------------------------------------------------------------
module argb_over_rgb565_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: src_alpha[7:0], src_red[15:8], src_green[23:16], src_blue[31:24],
  //        dest_pixel[47:32]
  input  logic [abr_pkg::InDataW-1:0]  s_axis_tdata,
  // stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: out_pixel[15:0]
  output logic [abr_pkg::OutDataW-1:0] m_axis_tdata,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [abr_pkg::ApbAddrW-1:0] paddr,
  input  logic [abr_pkg::ApbDataW-1:0] pwdata,
  output logic [abr_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  logic                         blend_enable;

  // input register
  logic                         s1_valid_q;
  logic                         s1_valid_d;
  abr_pkg::in_item_t            s1_item_q;
  logic                         s1_adv;
  logic                         in_acc;

  // result register
  logic                         out_valid_q;
  logic                         out_valid_d;
  logic [abr_pkg::OutDataW-1:0] out_pixel_q;
  logic [abr_pkg::OutDataW-1:0] out_pixel_d;

  // widened destination channels
  logic [abr_pkg::ChanW-1:0]    dst_red;
  logic [abr_pkg::ChanW-1:0]    dst_green;
  logic [abr_pkg::ChanW-1:0]    dst_blue;

  logic [abr_pkg::ChanW-1:0]    mix_red;
  logic [abr_pkg::ChanW-1:0]    mix_green;
  logic [abr_pkg::ChanW-1:0]    mix_blue;

  abr_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .blend_enable_o (blend_enable)
  );

  // handshake: stage 1 moves on whenever the result register is free or drains
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // rgb565 to 8 bits per channel by repeating the top bits
  assign dst_red   = {s1_item_q.dest_pixel[abr_pkg::RedHi:abr_pkg::RedLo],
                      s1_item_q.dest_pixel[abr_pkg::RedHi:abr_pkg::RedHi-2]};
  assign dst_green = {s1_item_q.dest_pixel[abr_pkg::GreenHi:abr_pkg::GreenLo],
                      s1_item_q.dest_pixel[abr_pkg::GreenHi:abr_pkg::GreenHi-1]};
  assign dst_blue  = {s1_item_q.dest_pixel[abr_pkg::BlueHi:abr_pkg::BlueLo],
                      s1_item_q.dest_pixel[abr_pkg::BlueHi:abr_pkg::BlueHi-2]};

  abr_mix u_mix_red (
    .src_i   (s1_item_q.src_red),
    .dst_i   (dst_red),
    .alpha_i (s1_item_q.src_alpha),
    .mix_o   (mix_red)
  );

  abr_mix u_mix_green (
    .src_i   (s1_item_q.src_green),
    .dst_i   (dst_green),
    .alpha_i (s1_item_q.src_alpha),
    .mix_o   (mix_green)
  );

  abr_mix u_mix_blue (
    .src_i   (s1_item_q.src_blue),
    .dst_i   (dst_blue),
    .alpha_i (s1_item_q.src_alpha),
    .mix_o   (mix_blue)
  );

  // blend on: pack the mixed channels; blend off: plain truncation of the source color
  always_comb begin
    if (blend_enable) begin
      out_pixel_d = abr_pkg::pack565(mix_red, mix_green, mix_blue);
    end else begin
      out_pixel_d = abr_pkg::pack565(s1_item_q.src_red, s1_item_q.src_green,
                                     s1_item_q.src_blue);
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= abr_pkg::in_item_t'(s_axis_tdata);
    end
    if (s1_adv) begin
      out_pixel_q <= out_pixel_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;

`ifndef NO_ASSERTIONS
  // both registers full and stalled: no room for a new pixel
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline full");

  // a pixel in stage 1 that cannot move stays there
  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("stage 1 pixel lost while stalled");

  // opaque alpha gives back the source channel
  a_opaque_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_item_q.src_alpha == 8'hFF |-> mix_red == s1_item_q.src_red)
    else $error("opaque blend differs from source");

  // transparent alpha keeps the widened destination
  a_clear_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_item_q.src_alpha == 8'h00 |-> mix_green == dst_green)
    else $error("transparent blend differs from destination");
`endif

endmodule
